[src/bmp_pkg.sv]
// ----------------------------------------------------------------------------
// bmp_pkg: shared types, constants and counter helpers
// Defaults for table and history sizes, the 2-bit counter arithmetic and
// the controller state type of the bi-mode direction predictor.
// ----------------------------------------------------------------------------
package bmp_pkg;

    localparam int PC_WIDTH                 = 48;
    localparam int CFG_WIDTH                = 4;
    localparam int CHOICE_INDEX_BITS_DEF    = 12;
    localparam int DIRECTION_INDEX_BITS_DEF = 12;
    localparam int HISTORY_BITS_DEF         = 12;
    localparam logic [CFG_WIDTH-1:0] HISTORY_LENGTH_RST = 4'd12;

    localparam logic [1:0] CTR_WEAK_TAKEN     = 2'd2;
    localparam logic [1:0] CTR_WEAK_NOT_TAKEN = 2'd1;
    localparam logic [1:0] CTR_MAX            = 2'd3;
    localparam logic [1:0] CTR_MIN            = 2'd0;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // counter predicts taken in its upper half
    function automatic logic ctr_dir(input logic [1:0] c);
        return c[1];
    endfunction

    // saturating up/down training
    function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic t);
        logic [1:0] r;
        r = c;
        if (t) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

[src/bimode_branch_predictor.sv]
// ----------------------------------------------------------------------------
// bimode_branch_predictor: bi-mode branch direction predictor
// Choice table selects a taken-biased or not-taken-biased direction counter;
// update transactions train both and shift the outcome into global history.
// ----------------------------------------------------------------------------
// Flow: accept reads both tables into their RAM read registers; in LOOKUP, once
//   the output is free, the result is registered and an update written back.
//   s_tready is high only in IDLE: no new transaction until LOOKUP is left.
// Reset: history clears, history_length returns to 12, then a clearing pass over
//   2**max(CHOICE_INDEX_BITS, DIRECTION_INDEX_BITS) entries (4096 by default)
//   writes the counter reset values; no input is taken during that pass.
module bimode_branch_predictor #(
    parameter int CHOICE_INDEX_BITS    = bmp_pkg::CHOICE_INDEX_BITS_DEF,
    parameter int DIRECTION_INDEX_BITS = bmp_pkg::DIRECTION_INDEX_BITS_DEF,
    parameter int HISTORY_BITS         = bmp_pkg::HISTORY_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: history_length
    input  logic                           cfg_wr_en,
    input  logic [bmp_pkg::CFG_WIDTH-1:0]  cfg_wr_data,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [55:0]                    s_tdata,  // [47:0] pc, [48] taken, rest zero
    input  logic                           s_tuser,  // [0] opcode (0 predict, 1 update)
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata   // [0] predict_taken,
                                                     // [1] used_taken_table, rest zero
);

    localparam int CLR_BITS = (CHOICE_INDEX_BITS > DIRECTION_INDEX_BITS) ?
                              CHOICE_INDEX_BITS : DIRECTION_INDEX_BITS;
    localparam int XW0      = (HISTORY_BITS > CHOICE_INDEX_BITS) ?
                              HISTORY_BITS : CHOICE_INDEX_BITS;
    localparam int XW       = (XW0 > DIRECTION_INDEX_BITS) ? XW0 : DIRECTION_INDEX_BITS;
    localparam int LEN_BITS = $clog2(HISTORY_BITS + 1) + 1;

    localparam logic [bmp_pkg::CFG_WIDTH-1:0] HISTORY_LENGTH_RST_C =
        bmp_pkg::HISTORY_LENGTH_RST;

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    bmp_pkg::state_t                    state_reg, state_next;
    logic [CLR_BITS-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [HISTORY_BITS-1:0]            hist_reg, hist_next;
    logic [bmp_pkg::CFG_WIDTH-1:0]      hlen_reg;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [1:0]                         m_res_reg, m_res_next;

    // item captured at accept, used while the tables are read
    logic                               op_reg;
    logic                               taken_reg;
    logic [CHOICE_INDEX_BITS-1:0]       cidx_reg;
    logic [DIRECTION_INDEX_BITS-1:0]    didx_reg;

    // ------------------------------------------------------------------
    // Input unpacking and index generation
    // ------------------------------------------------------------------
    logic [bmp_pkg::PC_WIDTH-1:0]       in_pc;
    logic                               in_taken;
    logic                               in_op;
    logic [CHOICE_INDEX_BITS-1:0]       pc_low;
    logic [LEN_BITS-1:0]                eff_len;
    logic [HISTORY_BITS-1:0]            hmask;
    logic [XW-1:0]                      mix;
    logic [DIRECTION_INDEX_BITS-1:0]    didx;
    logic                               accept;

    assign in_pc    = s_tdata[bmp_pkg::PC_WIDTH-1:0];
    assign in_taken = s_tdata[bmp_pkg::PC_WIDTH];
    assign in_op    = s_tuser;
    assign pc_low   = in_pc[CHOICE_INDEX_BITS-1:0];
    assign accept   = s_tvalid && s_tready;

    // saturate history_length to the history register width
    always_comb begin
        if (LEN_BITS'(hlen_reg) > LEN_BITS'(HISTORY_BITS)) begin
            eff_len = LEN_BITS'(HISTORY_BITS);
        end else begin
            eff_len = LEN_BITS'(hlen_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < HISTORY_BITS; i++) begin
            hmask[i] = (LEN_BITS'(i) < eff_len);
        end
    end

    assign mix  = XW'(hist_reg & hmask) ^ XW'(pc_low);
    assign didx = mix[DIRECTION_INDEX_BITS-1:0];

    // ------------------------------------------------------------------
    // Table memories: choice counters, and direction entries that pair the
    // taken-biased counter [3:2] with the not-taken-biased counter [1:0]
    // ------------------------------------------------------------------
    logic                               c_we, d_we;
    logic [CHOICE_INDEX_BITS-1:0]       c_waddr;
    logic [DIRECTION_INDEX_BITS-1:0]    d_waddr;
    logic [1:0]                         c_wdata, c_rdata;
    logic [3:0]                         d_wdata, d_rdata;

    bmp_ram #(
        .ADDR_BITS (CHOICE_INDEX_BITS),
        .DATA_BITS (2)
    ) u_choice_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .re    (accept),
        .raddr (pc_low),
        .rdata (c_rdata)
    );

    bmp_ram #(
        .ADDR_BITS (DIRECTION_INDEX_BITS),
        .DATA_BITS (4)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (accept),
        .raddr (didx),
        .rdata (d_rdata)
    );

    // ------------------------------------------------------------------
    // Lookup and training
    // ------------------------------------------------------------------
    logic       out_free;
    logic       finish;
    logic       use_taken;
    logic [1:0] sel_ctr;
    logic       pred;
    logic       skip_choice;
    logic [1:0] sel_trained;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign finish      = (state_reg == bmp_pkg::ST_LOOKUP) && out_free;
    assign use_taken   = bmp_pkg::ctr_dir(c_rdata);
    assign sel_ctr     = use_taken ? d_rdata[3:2] : d_rdata[1:0];
    assign pred        = bmp_pkg::ctr_dir(sel_ctr);
    // leave the choice alone when it was wrong but the chosen table was right
    assign skip_choice = (use_taken != taken_reg) && (pred == taken_reg);
    assign sel_trained = bmp_pkg::ctr_train(sel_ctr, taken_reg);

    // write port: clearing pass, else write back of a finished update
    always_comb begin
        if (state_reg == bmp_pkg::ST_CLEAR) begin
            c_we    = 1'b1;
            c_waddr = clr_cnt_reg[CHOICE_INDEX_BITS-1:0];
            c_wdata = bmp_pkg::CTR_WEAK_TAKEN;
            d_we    = 1'b1;
            d_waddr = clr_cnt_reg[DIRECTION_INDEX_BITS-1:0];
            d_wdata = {bmp_pkg::CTR_WEAK_TAKEN, bmp_pkg::CTR_WEAK_NOT_TAKEN};
        end else begin
            c_we    = finish && (op_reg == bmp_pkg::OP_UPDATE) && !skip_choice;
            c_waddr = cidx_reg;
            c_wdata = bmp_pkg::ctr_train(c_rdata, taken_reg);
            d_we    = finish && (op_reg == bmp_pkg::OP_UPDATE);
            d_waddr = didx_reg;
            d_wdata = use_taken ? {sel_trained, d_rdata[1:0]}
                                : {d_rdata[3:2], sel_trained};
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bmp_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            hist_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            hist_reg     <= hist_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hlen_reg <= HISTORY_LENGTH_RST_C;
        end else if (cfg_wr_en) begin
            hlen_reg <= cfg_wr_data;
        end
    end

    // hold the captured item while its tables are read
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= in_op;
            taken_reg <= in_taken;
            cidx_reg  <= pc_low;
            didx_reg  <= didx;
        end
        m_res_reg <= m_res_next;
    end

    always_comb begin
        logic [HISTORY_BITS:0] shifted;
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        hist_next     = hist_reg;
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        s_tready      = 1'b0;
        shifted       = {hist_reg, taken_reg};

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            bmp_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {CLR_BITS{1'b1}}) begin
                    state_next = bmp_pkg::ST_IDLE;
                end
            end
            bmp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = bmp_pkg::ST_LOOKUP;
                end
            end
            bmp_pkg::ST_LOOKUP: begin
                // advance only when the output register can take the result
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_res_next    = {use_taken, pred};
                    if (op_reg == bmp_pkg::OP_UPDATE) begin
                        hist_next = shifted[HISTORY_BITS-1:0];
                    end
                    state_next = bmp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmp_pkg::ST_CLEAR;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_res_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == bmp_pkg::ST_LOOKUP) && !s_tready)
        else $error("accepted transaction did not enter lookup");

    a_hist_only_on_update: assert property (@(posedge aclk) disable iff (!aresetn)
        !(finish && (op_reg == bmp_pkg::OP_UPDATE)) |=> $stable(hist_reg))
        else $error("history changed without a finished update");

    a_result_from_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == bmp_pkg::ST_LOOKUP))
        else $error("result appeared without a lookup");

    a_clear_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bmp_pkg::ST_CLEAR) && (clr_cnt_reg == {CLR_BITS{1'b1}})
        |=> (state_reg == bmp_pkg::ST_IDLE))
        else $error("clearing pass did not end");

endmodule

[src/bmp_ram.sv]
// ----------------------------------------------------------------------------
// bmp_ram: single write port, single read port synchronous RAM
// Read data is registered.
// ----------------------------------------------------------------------------
module bmp_ram #(
    parameter int ADDR_BITS = bmp_pkg::CHOICE_INDEX_BITS_DEF,
    parameter int DATA_BITS = 2
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[verif/bimode_branch_predictor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bimode_branch_predictor_tb: self-checking bench for the bi-mode predictor
// A clocked driver feeds predict and update transactions from a queue; an
// in-bench copy of the choice and direction tables predicts every result,
// and a clocked monitor compares each result field by field. Phases switch
// history_length between transactions while the block is idle.
// ----------------------------------------------------------------------------
module bimode_branch_predictor_tb;

    localparam int CIB        = bmp_pkg::CHOICE_INDEX_BITS_DEF;
    localparam int DIB        = bmp_pkg::DIRECTION_INDEX_BITS_DEF;
    localparam int HB         = bmp_pkg::HISTORY_BITS_DEF;
    localparam int IDLE_PCT   = 38;
    // a quiet stretch well past the reset clearing pass is taken as a hang
    localparam int QUIET_LIMIT = 20000;
    localparam int POOL_SIZE  = 24;

    typedef struct {
        logic        op;
        logic [47:0] pc;
        logic        taken;
    } branch_item_t;

    typedef struct {
        logic predict_taken;
        logic used_taken_table;
    } dir_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [bmp_pkg::CFG_WIDTH-1:0] cfg_wr_data = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [55:0]                   s_tdata = '0;   // [47:0] pc, [48] taken, rest zero
    logic                          s_tuser = 1'b0; // [0] opcode
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [7:0]                    m_tdata;        // [0] predict_taken, [1] used_taken_table

    // stimulus and expectation stores
    branch_item_t pending_branches[$];
    dir_result_t  expected_dirs[$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           no_idle = 1'b0;

    // shadow of the predictor state
    logic [1:0]                    choice_tbl   [0:(1<<CIB)-1];
    logic [1:0]                    taken_tbl    [0:(1<<DIB)-1];
    logic [1:0]                    not_taken_tbl[0:(1<<DIB)-1];
    logic [HB-1:0]                 global_hist;
    logic [bmp_pkg::CFG_WIDTH-1:0] hist_len;

    // hot branches reused by the random phases so the counters really train
    logic [47:0] pool_pc  [POOL_SIZE];
    int          pool_bias[POOL_SIZE];

    bimode_branch_predictor dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // 2-bit saturating counter step
    function automatic logic [1:0] bump_counter(input logic [1:0] c, input logic up);
        if (up) return (c == 2'd3) ? 2'd3 : c + 2'd1;
        return (c == 2'd0) ? 2'd0 : c - 2'd1;
    endfunction

    // Work out the result of one accepted transaction and train the shadow tables.
    task automatic predict_branch(input logic op, input logic [47:0] pc, input logic outcome);
        int          len;
        int          hmask;
        int          cidx;
        int          didx;
        logic        use_taken;
        logic        pred;
        logic        keep_choice;
        logic [1:0]  sel;
        dir_result_t res;
        len   = (hist_len > HB) ? HB : int'(hist_len);
        hmask = (1 << len) - 1;
        cidx  = int'(pc[CIB-1:0]);
        didx  = ((int'(global_hist) & hmask) ^ cidx) & ((1 << DIB) - 1);
        use_taken = (choice_tbl[cidx] >= 2'd2);
        sel   = use_taken ? taken_tbl[didx] : not_taken_tbl[didx];
        pred  = (sel >= 2'd2);
        res.predict_taken    = pred;
        res.used_taken_table = use_taken;
        expected_dirs.push_back(res);
        if (op == bmp_pkg::OP_UPDATE) begin
            // leave the choice alone when it was wrong but the chosen table was right
            keep_choice = (use_taken != outcome) && (pred == outcome);
            if (use_taken) taken_tbl[didx] = bump_counter(sel, outcome);
            else not_taken_tbl[didx] = bump_counter(sel, outcome);
            if (!keep_choice) choice_tbl[cidx] = bump_counter(choice_tbl[cidx], outcome);
            global_hist = {global_hist[HB-2:0], outcome};
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next queued transaction, hold it until accepted, and
    // predict each one at the edge where it is accepted.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_branches
        branch_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            // mirror the clearing pass of the block
            for (int i = 0; i < (1 << CIB); i++) choice_tbl[i] = bmp_pkg::CTR_WEAK_TAKEN;
            for (int i = 0; i < (1 << DIB); i++) begin
                taken_tbl[i]     = bmp_pkg::CTR_WEAK_TAKEN;
                not_taken_tbl[i] = bmp_pkg::CTR_WEAK_NOT_TAKEN;
            end
            global_hist = '0;
            hist_len    = bmp_pkg::HISTORY_LENGTH_RST;
        end else begin
            if (cfg_wr_en) hist_len = cfg_wr_data;
            if (s_tvalid && s_tready) predict_branch(s_tuser, s_tdata[47:0], s_tdata[48]);
            // advance only when the current transaction is gone or none is up
            if (!s_tvalid || s_tready) begin
                if (pending_branches.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    item = pending_branches.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, item.taken, item.pc};
                    s_tuser  <= item.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stall at random, compare each accepted result with the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        dir_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_dirs.size() == 0) begin
                    report_mismatch($sformatf("result 0x%02h with nothing expected", m_tdata));
                end else begin
                    want = expected_dirs.pop_front();
                    if (m_tdata[0] !== want.predict_taken)
                        report_mismatch($sformatf("predict_taken got %b want %b",
                                                  m_tdata[0], want.predict_taken));
                    if (m_tdata[1] !== want.used_taken_table)
                        report_mismatch($sformatf("used_taken_table got %b want %b",
                                                  m_tdata[1], want.used_taken_table));
                end
            end
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL bimode_branch_predictor");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_branch(input logic op, input logic [47:0] pc, input logic taken);
        branch_item_t item;
        item.op    = op;
        item.pc    = pc;
        item.taken = taken;
        pending_branches.push_back(item);
    endtask

    function automatic logic [47:0] random_pc();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[47:0];
    endfunction

    // Mostly hot branches with per-branch bias, the rest pure noise.
    task automatic add_random_branches(input int count);
        int          k;
        logic        op;
        logic [47:0] pc;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 85) begin
                k  = $urandom_range(POOL_SIZE - 1);
                op = ($urandom_range(99) < 80) ? bmp_pkg::OP_UPDATE : bmp_pkg::OP_PREDICT;
                add_branch(op, pool_pc[k], $urandom_range(99) < pool_bias[k]);
            end else begin
                op = $urandom_range(1) ? bmp_pkg::OP_UPDATE : bmp_pkg::OP_PREDICT;
                pc = random_pc();
                add_branch(op, pc, 1'($urandom_range(1)));
            end
        end
    endtask

    // Hold until every transaction is sent and answered, then let the
    // counter write-back settle.
    task automatic wait_for_drain(input int settle);
        while (pending_branches.size() != 0 || s_tvalid || expected_dirs.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_history_length(input logic [bmp_pkg::CFG_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : run_phases
        logic [47:0] hot_pc;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pc[i] = random_pc();
            // alias a few hot branches onto the same choice entry
            if (i >= 2 && i % 6 == 0) pool_pc[i][CIB-1:0] = pool_pc[i-1][CIB-1:0];
            case (i % 4)
                0: begin
                    pool_bias[i] = 95;
                end
                1: begin
                    pool_bias[i] = 5;
                end
                2: begin
                    pool_bias[i] = 70;
                end
                default: begin
                    pool_bias[i] = 30;
                end
            endcase
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset history length: field extremes, aliasing pcs, ignored outcome.
        add_branch(bmp_pkg::OP_PREDICT, 48'h0000_0000_0000, 1'b0);
        add_branch(bmp_pkg::OP_PREDICT, 48'hFFFF_FFFF_FFFF, 1'b1);
        add_branch(bmp_pkg::OP_UPDATE,  48'hFFFF_FFFF_FFFF, 1'b1);
        add_branch(bmp_pkg::OP_UPDATE,  48'h0000_0000_0000, 1'b0);
        add_branch(bmp_pkg::OP_UPDATE,  48'h8000_0000_0000, 1'b1);
        add_branch(bmp_pkg::OP_UPDATE,  48'h5000_0000_0ABC, 1'b0);
        add_branch(bmp_pkg::OP_PREDICT, 48'h0000_0000_0ABC, 1'b1);
        add_branch(bmp_pkg::OP_UPDATE,  48'hAAAA_AAAA_AAAA, 1'b1);
        add_branch(bmp_pkg::OP_UPDATE,  48'h5555_5555_5555, 1'b0);
        wait_for_drain(4);

        // No history: walk one counter pair through choice skip and saturation.
        write_history_length(4'd0);
        hot_pc = 48'h0000_0000_0123;
        add_branch(bmp_pkg::OP_UPDATE,  hot_pc, 1'b0);
        add_branch(bmp_pkg::OP_UPDATE,  hot_pc, 1'b1);
        add_branch(bmp_pkg::OP_UPDATE,  hot_pc, 1'b0);  // choice wrong, chosen counter right
        add_branch(bmp_pkg::OP_PREDICT, hot_pc, 1'b1);
        repeat (4) add_branch(bmp_pkg::OP_UPDATE, hot_pc, 1'b1);
        repeat (4) add_branch(bmp_pkg::OP_UPDATE, hot_pc, 1'b0);
        add_branch(bmp_pkg::OP_PREDICT, hot_pc, 1'b0);
        wait_for_drain(4);

        // Above the history width: saturates to the full history.
        write_history_length(4'd15);
        add_random_branches(90);
        wait_for_drain(4);

        write_history_length(4'd0);
        add_random_branches(90);
        wait_for_drain(4);

        write_history_length(4'd1);
        add_random_branches(90);
        wait_for_drain(4);

        // back-to-back stretch with no idling on either side
        write_history_length(4'd6);
        no_idle = 1'b1;
        add_random_branches(90);
        wait_for_drain(4);
        no_idle = 1'b0;

        write_history_length(4'd12);
        add_random_branches(90);
        wait_for_drain(4);

        write_history_length(4'($urandom_range(15)));
        add_random_branches(100);
        wait_for_drain(10);

        if (expected_dirs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_dirs.size()));
        if (error_count == 0) begin
            $display("PASS bimode_branch_predictor");
        end else begin
            $display("FAIL bimode_branch_predictor");
        end
        $finish;
    end

endmodule
